FILE: rtl/eon_pkg.sv
`default_nettype none
package eon_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int ALBEDO_W = 17;
    localparam int COS_W    = 18;
    localparam int REFL_W   = 17;
    localparam int REFL_MAX = 131071;

    // Constants with 32 fraction bits
    localparam longint C32_INV_PI = 64'sd1367130551;
    localparam longint C32_CA     = 64'sd1236063277;
    localparam longint C32_CB     = 64'sd311334500;
    localparam longint C32_G3     = 64'sd306845238;
    localparam longint C32_G2     = -64'sd1426708417;
    localparam longint C32_G1     = 64'sd2112616532;
    localparam longint C32_G0     = 64'sd245279264;

    // Round a 32-fraction-bit constant to f fraction bits, halves away from zero
    function automatic longint cst(longint c32, int f);
        longint m;
        m = (c32 < 0) ? -c32 : c32;
        m = (m + (64'sd1 <<< (31 - f))) >>> (32 - f);
        return (c32 < 0) ? -m : m;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/eon_sample_if.sv
`default_nettype none
interface eon_sample_if
    import eon_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic        [ALBEDO_W-1:0] albedo_red;
    logic        [ALBEDO_W-1:0] albedo_green;
    logic        [ALBEDO_W-1:0] albedo_blue;
    logic        [ALBEDO_W-1:0] rough;
    logic signed [COS_W-1:0]    cos_normal_view;
    logic signed [COS_W-1:0]    cos_normal_light;
    logic signed [COS_W-1:0]    cos_light_view;

    modport source (
        output valid, albedo_red, albedo_green, albedo_blue, rough,
               cos_normal_view, cos_normal_light, cos_light_view,
        input  ready
    );
    modport sink (
        input  valid, albedo_red, albedo_green, albedo_blue, rough,
               cos_normal_view, cos_normal_light, cos_light_view,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/eon_bsdf_if.sv
`default_nettype none
interface eon_bsdf_if
    import eon_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [REFL_W-1:0] reflect_red;
    logic [REFL_W-1:0] reflect_green;
    logic [REFL_W-1:0] reflect_blue;

    modport source (
        output valid, reflect_red, reflect_green, reflect_blue,
        input  ready
    );
    modport sink (
        input  valid, reflect_red, reflect_green, reflect_blue,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/eon_diffuse_bsdf_eval_core.sv
// Throughput: one sample per cycle; the whole pipeline advances together and
// holds only while a finished result waits at the output and is not taken.
// Each of the two divide rounds is a restoring divider of FRAC_BITS + 14 stages.
// Reset (rst_n, asynchronous, active low) clears the stage valid bits only.
`default_nettype none
module eon_diffuse_bsdf_eval_core
    import eon_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    eon_sample_if.sink  sample,
    eon_bsdf_if.source  bsdf
);
    localparam int F   = FRAC_BITS;
    localparam int W   = F + 15;
    localparam int LD  = F + 14;
    localparam int TB  = 2 * LD + 8;
    localparam int NS  = TB + 2;
    localparam logic signed [W-1:0] ONE = W'(1) << F;
    localparam logic signed [W-1:0] EPS = W'(1);

    logic          adv;
    logic [NS-1:0] vld_reg;

    assign adv          = !vld_reg[NS-1] || bsdf.ready;
    assign sample.ready = adv;
    assign bsdf.valid   = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], sample.valid};
    end

    // input rescale to FRAC_BITS
    logic [W-1:0]        ucol [3];
    logic [W-1:0]        ur;
    logic [W-1:0]        ucos [3];
    logic [ALBEDO_W-1:0] ain  [3];
    logic [COS_W-1:0]    cin  [3];
    logic [W-1:0]        uin  [4];
    logic [W-1:0]        umag [4];
    logic [W-1:0]        cmag [3];
    logic [W-1:0]        cres [3];

    assign ain[0] = sample.albedo_red;
    assign ain[1] = sample.albedo_green;
    assign ain[2] = sample.albedo_blue;
    assign cin[0] = sample.cos_normal_view;
    assign cin[1] = sample.cos_normal_light;
    assign cin[2] = sample.cos_light_view;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            uin[k]  = W'(ain[k]);
            cmag[k] = cin[k][COS_W-1] ? W'(COS_W'(~cin[k] + 1'b1)) : W'(cin[k]);
        end
        uin[3] = W'(sample.rough);
    end

    if (F >= 16)
    begin : g_up
        always_comb
        begin
            for (int k = 0; k < 4; k++)
                umag[k] = uin[k] << (F - 16);
            for (int k = 0; k < 3; k++)
                cres[k] = cmag[k] << (F - 16);
        end
    end
    else
    begin : g_dn
        always_comb
        begin
            for (int k = 0; k < 4; k++)
                umag[k] = (uin[k] + (W'(1) << (15 - F))) >> (16 - F);
            for (int k = 0; k < 3; k++)
                cres[k] = (cmag[k] + (W'(1) << (15 - F))) >> (16 - F);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ucol[k] = umag[k];
            ucos[k] = cin[k][COS_W-1] ? (~cres[k] + 1'b1) : cres[k];
        end
        ur = (umag[3] > ONE) ? ONE : umag[3];
    end

    logic signed [W-1:0] col0_reg [3];
    logic signed [W-1:0] r0_reg, mui0_reg, muo0_reg, lv0_reg;
    logic                rz0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
                col0_reg[k] <= ucol[k];
            r0_reg   <= ur;
            rz0_reg  <= (ur == '0);
            muo0_reg <= ($signed(ucos[0]) > EPS) ? ucos[0] : EPS;
            mui0_reg <= ($signed(ucos[1]) > EPS) ? ucos[1] : EPS;
            lv0_reg  <= ucos[2];
        end
    end

    logic signed [W-1:0] eavg, ss, ms;

    eon_shared #(.F(F)) u_shared (
        .clk,
        .adv,
        .r0   (r0_reg),
        .mui0 (mui0_reg),
        .muo0 (muo0_reg),
        .lv0  (lv0_reg),
        .eavg (eavg),
        .ss   (ss),
        .ms   (ms)
    );

    logic rz_b;

    eon_dly #(.WIDTH(1), .DEPTH(TB)) u_dly_rz (.clk, .adv, .d(rz0_reg), .q(rz_b));

    logic [REFL_W-1:0] refl [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic signed [W-1:0] col_a;

        eon_dly #(.WIDTH(W), .DEPTH(LD + 6)) u_dly_col (
            .clk, .adv, .d(col0_reg[k]), .q(col_a)
        );

        eon_lane #(.F(F)) u_lane (
            .clk,
            .adv,
            .col  (col_a),
            .eavg (eavg),
            .rz   (rz_b),
            .ss   (ss),
            .ms   (ms),
            .refl (refl[k])
        );
    end

    assign bsdf.reflect_red   = refl[0];
    assign bsdf.reflect_green = refl[1];
    assign bsdf.reflect_blue  = refl[2];
endmodule
`default_nettype wire

FILE: rtl/eon_mul.sv
`default_nettype none
module eon_mul
    import eon_pkg::*;
#(
    parameter int F = FRAC_BITS_DEF
) (
    input  wire logic signed [F+14:0] a,
    input  wire logic signed [F+14:0] b,
    output logic signed [F+14:0]      p
);
    localparam int W  = F + 15;
    localparam int PW = 2 * W;
    localparam logic [PW-1:0] HALF  = PW'(1) << (F - 1);
    localparam logic [PW-1:0] LIMIT = PW'(4096) << F;

    logic [W-1:0]  ma;
    logic [W-1:0]  mb;
    logic [PW-1:0] prod;
    logic [PW-1:0] rnd;
    logic [PW-1:0] sat;
    logic [W-1:0]  mag;

    always_comb
    begin
        ma   = a[W-1] ? (~a + 1'b1) : a;
        mb   = b[W-1] ? (~b + 1'b1) : b;
        prod = PW'(ma) * PW'(mb);
        rnd  = (prod + HALF) >> F;
        sat  = (rnd > LIMIT) ? LIMIT : rnd;
        mag  = sat[W-1:0];
        p    = (a[W-1] ^ b[W-1]) ? (~mag + 1'b1) : mag;
    end
endmodule
`default_nettype wire

FILE: rtl/eon_div.sv
`default_nettype none
module eon_div
    import eon_pkg::*;
#(
    parameter int F = FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                adv,
    input  wire logic signed [F+14:0] a,
    input  wire logic signed [F+14:0] b,
    output logic signed [F+14:0]      q
);
    // Restoring divider, one quotient bit per stage
    localparam int W  = F + 15;
    localparam int QB = F + 13;
    localparam int XW = 2 * F + 28;
    localparam logic [W-1:0]  LIMIT_W = W'(4096) << F;
    localparam logic [XW-1:0] LIMIT_X = XW'(4096) << F;

    logic [XW-1:0] rem_reg [QB+1];
    logic [QB-1:0] quo_reg [QB+1];
    logic [W-1:0]  mb_reg  [QB+1];
    logic          neg_reg [QB+1];
    logic          ovf_reg [QB+1];

    logic [W-1:0]  ma_abs;
    logic [W-1:0]  ma_sat;
    logic [W-1:0]  mb;
    logic [XW-1:0] num;

    always_comb
    begin
        ma_abs = a[W-1] ? (~a + 1'b1) : a;
        ma_sat = (ma_abs > LIMIT_W) ? LIMIT_W : ma_abs;
        mb     = (!b[W-1] && (b != '0)) ? b : W'(1);
        num    = (XW'(ma_sat) << F) + XW'(mb >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= num;
            quo_reg[0] <= '0;
            mb_reg[0]  <= mb;
            neg_reg[0] <= a[W-1];
            ovf_reg[0] <= num >= (XW'(mb) << QB);
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_stage
        logic [XW-1:0] sub;
        logic          ge;
        assign sub = XW'(mb_reg[j-1]) << (QB - j);
        assign ge  = rem_reg[j-1] >= sub;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j] <= ge ? (rem_reg[j-1] - sub) : rem_reg[j-1];
                quo_reg[j] <= quo_reg[j-1] | (QB'(ge) << (QB - j));
                mb_reg[j]  <= mb_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    logic [W-1:0] qmag;

    always_comb
    begin
        if (ovf_reg[QB] || (XW'(quo_reg[QB]) > LIMIT_X))
            qmag = LIMIT_W;
        else
            qmag = W'(quo_reg[QB]);
        q = neg_reg[QB] ? (~qmag + 1'b1) : qmag;
    end
endmodule
`default_nettype wire

FILE: rtl/eon_dly.sv
`default_nettype none
module eon_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             adv,
    input  wire logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0]      q
);
    logic [WIDTH-1:0] sr_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sr_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign q = sr_reg[DEPTH-1];
endmodule
`default_nettype wire

FILE: rtl/eon_shared.sv
`default_nettype none
module eon_shared
    import eon_pkg::*;
#(
    parameter int F = FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 adv,
    input  wire logic signed [F+14:0] r0,
    input  wire logic signed [F+14:0] mui0,
    input  wire logic signed [F+14:0] muo0,
    input  wire logic signed [F+14:0] lv0,
    output logic signed [F+14:0]      eavg,
    output logic signed [F+14:0]      ss,
    output logic signed [F+14:0]      ms
);
    localparam int W  = F + 15;
    localparam int LD = F + 14;
    localparam logic signed [W-1:0] ONE  = W'(1) << F;
    localparam logic signed [W-1:0] EPS  = W'(1);
    localparam logic signed [W-1:0] K_PI = W'(cst(C32_INV_PI, F));
    localparam logic signed [W-1:0] K_CA = W'(cst(C32_CA, F));
    localparam logic signed [W-1:0] K_CB = W'(cst(C32_CB, F));
    localparam logic signed [W-1:0] KG [4] = '{
        W'(cst(C32_G3, F)), W'(cst(C32_G2, F)),
        W'(cst(C32_G1, F)), W'(cst(C32_G0, F))
    };

    // stage 1
    logic signed [W-1:0] pmu, car, cbr;
    logic signed [W-1:0] s1_reg, mx1_reg, dena1_reg, cbr1_reg;
    logic signed [W-1:0] r_reg [4];
    logic signed [W-1:0] qc [2];
    logic signed [W-1:0] mu0 [2];

    eon_mul #(.F(F)) u_mul_mu (.a(mui0), .b(muo0), .p(pmu));
    eon_mul #(.F(F)) u_mul_ca (.a(K_CA), .b(r0),   .p(car));
    eon_mul #(.F(F)) u_mul_cb (.a(K_CB), .b(r0),   .p(cbr));

    assign mu0[0] = mui0;
    assign mu0[1] = muo0;

    always_comb
    begin
        for (int d = 0; d < 2; d++)
        begin
            if (mu0[d] < 0)
                qc[d] = ONE;
            else if (mu0[d] > ONE)
                qc[d] = '0;
            else
                qc[d] = ONE - mu0[d];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg    <= lv0 - pmu;
            mx1_reg   <= (mui0 > muo0) ? mui0 : muo0;
            dena1_reg <= ONE + car;
            cbr1_reg  <= ONE + cbr;
            r_reg[0]  <= r0;
            for (int j = 1; j < 4; j++)
            begin
                r_reg[j] <= r_reg[j-1];
            end
        end
    end

    // cubic fit of directional albedo, one Horner step per stage
    logic signed [W-1:0] q_reg [2][4];
    logic signed [W-1:0] g_reg [2][4];
    logic signed [W-1:0] n5_reg [2];

    for (genvar d = 0; d < 2; d++)
    begin : g_dir
        for (genvar j = 0; j < 4; j++)
        begin : g_horner
            logic signed [W-1:0] qop, kop, gp;
            if (j == 0)
            begin : g_first
                assign qop = qc[d];
                assign kop = KG[0];
            end
            else
            begin : g_next
                assign qop = q_reg[d][j-1];
                assign kop = KG[j] + g_reg[d][j-1];
            end
            eon_mul #(.F(F)) u_mul_g (.a(qop), .b(kop), .p(gp));
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    q_reg[d][j] <= qop;
                    g_reg[d][j] <= gp;
                end
            end
        end

        logic signed [W-1:0] rg;
        eon_mul #(.F(F)) u_mul_rg (.a(r_reg[3]), .b(g_reg[d][3]), .p(rg));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                n5_reg[d] <= ONE + rg;
            end
        end
    end

    // align to stage 5
    logic signed [W-1:0] s5, mx5, dena5, cbr_a, r_a, s_a;

    eon_dly #(.WIDTH(W), .DEPTH(4))      u_dly_s   (.clk, .adv, .d(s1_reg),    .q(s5));
    eon_dly #(.WIDTH(W), .DEPTH(4))      u_dly_mx  (.clk, .adv, .d(mx1_reg),   .q(mx5));
    eon_dly #(.WIDTH(W), .DEPTH(4))      u_dly_den (.clk, .adv, .d(dena1_reg), .q(dena5));
    eon_dly #(.WIDTH(W), .DEPTH(4 + LD)) u_dly_cbr (.clk, .adv, .d(cbr1_reg),  .q(cbr_a));
    eon_dly #(.WIDTH(W), .DEPTH(1 + LD)) u_dly_r   (.clk, .adv, .d(r_reg[3]),  .q(r_a));
    eon_dly #(.WIDTH(W), .DEPTH(LD))     u_dly_sa  (.clk, .adv, .d(s5),        .q(s_a));

    // first divide round
    logic signed [W-1:0] sfq, af, ei, eo, sf;

    eon_div #(.F(F)) u_div_sf (.clk, .adv, .a(s5),        .b(mx5),   .q(sfq));
    eon_div #(.F(F)) u_div_af (.clk, .adv, .a(ONE),       .b(dena5), .q(af));
    eon_div #(.F(F)) u_div_ei (.clk, .adv, .a(n5_reg[0]), .b(dena5), .q(ei));
    eon_div #(.F(F)) u_div_eo (.clk, .adv, .a(n5_reg[1]), .b(dena5), .q(eo));

    assign sf = (s_a > 0) ? sfq : s_a;

    // post stage 1
    logic signed [W-1:0] ss1p, eav1p, rsfp;
    logic signed [W-1:0] ss1_reg, eavg1_reg, rsf1_reg, omi1_reg, omo1_reg;

    eon_mul #(.F(F)) u_mul_ss1 (.a(K_PI), .b(af),    .p(ss1p));
    eon_mul #(.F(F)) u_mul_eav (.a(af),   .b(cbr_a), .p(eav1p));
    eon_mul #(.F(F)) u_mul_rsf (.a(r_a),  .b(sf),    .p(rsfp));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ss1_reg   <= ss1p;
            eavg1_reg <= eav1p;
            rsf1_reg  <= ONE + rsfp;
            omi1_reg  <= ((ONE - ei) > EPS) ? (ONE - ei) : EPS;
            omo1_reg  <= ((ONE - eo) > EPS) ? (ONE - eo) : EPS;
        end
    end

    // post stage 2
    logic signed [W-1:0] ss2p, m1p;
    logic signed [W-1:0] ss2_reg, m1_reg, omo2_reg, ome2_reg;

    eon_mul #(.F(F)) u_mul_ss2 (.a(ss1_reg), .b(rsf1_reg), .p(ss2p));
    eon_mul #(.F(F)) u_mul_m1  (.a(K_PI),    .b(omi1_reg), .p(m1p));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ss2_reg  <= ss2p;
            m1_reg   <= m1p;
            omo2_reg <= omo1_reg;
            ome2_reg <= ((ONE - eavg1_reg) > EPS) ? (ONE - eavg1_reg) : EPS;
        end
    end

    // post stage 3
    logic signed [W-1:0] msnp;
    logic signed [W-1:0] msn3_reg, ome3_reg;

    eon_mul #(.F(F)) u_mul_msn (.a(m1_reg), .b(omo2_reg), .p(msnp));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            msn3_reg <= msnp;
            ome3_reg <= ome2_reg;
        end
    end

    eon_div #(.F(F)) u_div_ms (.clk, .adv, .a(msn3_reg), .b(ome3_reg), .q(ms));
    eon_dly #(.WIDTH(W), .DEPTH(LD + 1)) u_dly_ss (.clk, .adv, .d(ss2_reg), .q(ss));

    assign eavg = eavg1_reg;
endmodule
`default_nettype wire

FILE: rtl/eon_lane.sv
`default_nettype none
module eon_lane
    import eon_pkg::*;
#(
    parameter int F = FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 adv,
    input  wire logic signed [F+14:0] col,
    input  wire logic signed [F+14:0] eavg,
    input  wire logic                 rz,
    input  wire logic signed [F+14:0] ss,
    input  wire logic signed [F+14:0] ms,
    output logic [REFL_W-1:0]         refl
);
    localparam int W  = F + 15;
    localparam int LD = F + 14;
    localparam int XW = W + 16;
    localparam logic signed [W-1:0] ONE  = W'(1) << F;
    localparam logic signed [W-1:0] EPS  = W'(1);
    localparam logic signed [W-1:0] K_PI = W'(cst(C32_INV_PI, F));

    logic signed [W-1:0] sqp, tp, nump;
    logic signed [W-1:0] sq2_reg, t2_reg, eavg2_reg, num3_reg, den3_reg;

    eon_mul #(.F(F)) u_mul_sq (.a(col), .b(col),        .p(sqp));
    eon_mul #(.F(F)) u_mul_t  (.a(col), .b(ONE - eavg), .p(tp));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq2_reg   <= sqp;
            t2_reg    <= tp;
            eavg2_reg <= eavg;
        end
    end

    eon_mul #(.F(F)) u_mul_num (.a(sq2_reg), .b(eavg2_reg), .p(nump));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num3_reg <= nump;
            den3_reg <= ((ONE - t2_reg) > EPS) ? (ONE - t2_reg) : EPS;
        end
    end

    logic signed [W-1:0] rho, col_b;

    eon_div #(.F(F)) u_div_rho (.clk, .adv, .a(num3_reg), .b(den3_reg), .q(rho));
    eon_dly #(.WIDTH(W), .DEPTH(LD + 2)) u_dly_col (.clk, .adv, .d(col), .q(col_b));

    // zero roughness: albedo/pi only
    logic signed [W-1:0] fa, fb, tot;
    logic [XW-1:0]       ext, m;

    eon_mul #(.F(F)) u_mul_fa (.a(col_b), .b(rz ? K_PI : ss), .p(fa));
    eon_mul #(.F(F)) u_mul_fb (.a(rho),   .b(ms),             .p(fb));

    assign tot = fa + (rz ? W'(0) : fb);
    assign ext = XW'(tot);

    if (F <= 16)
    begin : g_up
        assign m = ext << (16 - F);
    end
    else
    begin : g_dn
        assign m = (ext + (XW'(1) << (F - 17))) >> (F - 16);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (tot <= 0)
                refl <= '0;
            else if (m > XW'(REFL_MAX))
                refl <= REFL_W'(REFL_MAX);
            else
                refl <= m[REFL_W-1:0];
        end
    end
endmodule
`default_nettype wire

FILE: verif/eon_diffuse_bsdf_eval_core_tb.sv
`timescale 1ns / 100ps
module eon_diffuse_bsdf_eval_core_tb;
    import eon_pkg::*;

    localparam int FB         = 16;
    localparam int HOLD_LEN   = 400;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 120;
    localparam int N_RANDOM   = 1950;

    typedef struct {
        logic        [ALBEDO_W-1:0] alb [3];
        logic        [ALBEDO_W-1:0] rough;
        logic signed [COS_W-1:0]    cnv;
        logic signed [COS_W-1:0]    cnl;
        logic signed [COS_W-1:0]    clv;
    } shade_sample_t;

    typedef struct {
        logic [REFL_W-1:0] refl [3];
    } bsdf_value_t;

    class bsdf_scoreboard;
        bsdf_value_t expected_q[$];
        int          mismatches;

        localparam longint ONE   = 64'sd1 <<< FB;
        localparam longint LIMIT = 64'sd4096 <<< FB;

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        function longint clip_signed(bit neg, longint unsigned m);
            if (m > LIMIT)
                m = LIMIT;
            return neg ? -longint'(m) : longint'(m);
        endfunction

        // round a constant held with 32 fraction bits to FB bits
        function longint k32(longint c32);
            longint unsigned m;
            m = (mag(c32) + (64'd1 << (31 - FB))) >> (32 - FB);
            return clip_signed(c32 < 0, m);
        endfunction

        function longint fmul(longint a, longint b);
            longint unsigned ma, mb, p, half;
            ma   = mag(a);
            mb   = mag(b);
            half = 64'd1 << (FB - 1);
            if (mb != 0 && ma > (64'hFFFF_FFFF_FFFF_FFFF - half) / mb)
                p = LIMIT;
            else
                p = (ma * mb + half) >> FB;
            return clip_signed((a < 0) != (b < 0), p);
        endfunction

        function longint fdiv(longint a, longint b);
            longint unsigned ma, mb;
            ma = mag(a);
            mb = b > 0 ? longint'(b) : 1;
            if (ma > LIMIT)
                ma = LIMIT;
            return clip_signed(a < 0, ((ma << FB) + mb / 2) / mb);
        endfunction

        function longint fmax(longint a, longint b);
            return a > b ? a : b;
        endfunction

        function logic [REFL_W-1:0] to_refl(longint v);
            if (v <= 0)
                return '0;
            return v > REFL_MAX ? REFL_MAX[REFL_W-1:0] : v[REFL_W-1:0];
        endfunction

        // cubic fit of directional albedo
        function longint dir_albedo(longint mu, longint r, longint ca);
            longint c, q, g;
            c = mu < 0 ? 0 : (mu > ONE ? ONE : mu);
            q = ONE - c;
            g = fmul(q, k32(C32_G3));
            g = fmul(q, k32(C32_G2) + g);
            g = fmul(q, k32(C32_G1) + g);
            g = fmul(q, k32(C32_G0) + g);
            return fdiv(ONE + fmul(r, g), ONE + fmul(ca, r));
        endfunction

        function bsdf_value_t eval_bsdf(shade_sample_t x);
            bsdf_value_t res;
            longint inv_pi, ca, cb, r, mu_i, mu_o, s, sf, af, ss, ei, eo, eavg, ms;
            longint col [3];
            longint num, den, rho;
            inv_pi = k32(C32_INV_PI);
            ca     = k32(C32_CA);
            cb     = k32(C32_CB);
            for (int k = 0; k < 3; k++)
                col[k] = longint'(x.alb[k]);
            r = longint'(x.rough);
            if (r > ONE)
                r = ONE;
            if (r == 0)
            begin
                for (int k = 0; k < 3; k++)
                    res.refl[k] = to_refl(fmul(col[k], inv_pi));
                return res;
            end
            mu_o = fmax(longint'(x.cnv), 1);
            mu_i = fmax(longint'(x.cnl), 1);
            s    = longint'(x.clv) - fmul(mu_i, mu_o);
            sf   = s > 0 ? fdiv(s, fmax(mu_i, mu_o)) : s;
            af   = fdiv(ONE, ONE + fmul(ca, r));
            ss   = fmul(fmul(inv_pi, af), ONE + fmul(r, sf));
            ei   = dir_albedo(mu_i, r, ca);
            eo   = dir_albedo(mu_o, r, ca);
            eavg = fmul(af, ONE + fmul(cb, r));
            ms   = fmul(fmul(inv_pi, fmax(1, ONE - ei)), fmax(1, ONE - eo));
            ms   = fdiv(ms, fmax(1, ONE - eavg));
            for (int k = 0; k < 3; k++)
            begin
                num = fmul(fmul(col[k], col[k]), eavg);
                den = fmax(1, ONE - fmul(col[k], ONE - eavg));
                rho = fdiv(num, den);
                res.refl[k] = to_refl(fmul(col[k], ss) + fmul(rho, ms));
            end
            return res;
        endfunction

        function void note_sample(shade_sample_t x);
            expected_q.push_back(eval_bsdf(x));
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH %s: got %0d expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_bsdf(bsdf_value_t got);
            bsdf_value_t want;
            string chan [3];
            chan = '{"reflect_red", "reflect_green", "reflect_blue"};
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            want = expected_q.pop_front();
            for (int k = 0; k < 3; k++)
                if (got.refl[k] !== want.refl[k])
                    report_mismatch(chan[k], int'(got.refl[k]), int'(want.refl[k]));
        endtask
    endclass

    logic clk;
    logic rst_n;

    eon_sample_if sample ();
    eon_bsdf_if   bsdf ();

    eon_diffuse_bsdf_eval_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .bsdf   (bsdf.source)
    );

    bsdf_scoreboard sb;
    int             phase;
    bit             hold_req;
    int             cycles = 0;
    int             send_idle_pct [3] = '{34, 73, 0};
    int             recv_idle_pct [3] = '{73, 34, 0};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        sb       = new();
        phase    = 0;
        hold_req = 1'b0;
        rst_n    = 1'b0;
        sample.valid            <= 1'b0;
        sample.albedo_red       <= '0;
        sample.albedo_green     <= '0;
        sample.albedo_blue      <= '0;
        sample.rough            <= '0;
        sample.cos_normal_view  <= '0;
        sample.cos_normal_light <= '0;
        sample.cos_light_view   <= '0;
        bsdf.ready              <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // scoreboard taps on both channels
    always @(posedge clk)
    begin
        shade_sample_t sx;
        bsdf_value_t   bx;
        if (rst_n && sample.valid && sample.ready)
        begin
            sx.alb[0] = sample.albedo_red;
            sx.alb[1] = sample.albedo_green;
            sx.alb[2] = sample.albedo_blue;
            sx.rough  = sample.rough;
            sx.cnv    = sample.cos_normal_view;
            sx.cnl    = sample.cos_normal_light;
            sx.clv    = sample.cos_light_view;
            sb.note_sample(sx);
        end
        if (rst_n && bsdf.valid && bsdf.ready)
        begin
            bx.refl[0] = bsdf.reflect_red;
            bx.refl[1] = bsdf.reflect_green;
            bx.refl[2] = bsdf.reflect_blue;
            sb.check_bsdf(bx);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int held;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                bsdf.ready <= 1'b0;
                for (held = 1; held < HOLD_LEN; held++)
                    @(posedge clk);
                hold_req <= 1'b0;
                @(posedge clk);
            end
            bsdf.ready <= ($urandom_range(99) >= recv_idle_pct[phase]);
        end
    end

    task automatic send_sample(shade_sample_t x);
        while ($urandom_range(99) < send_idle_pct[phase])
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid            <= 1'b1;
        sample.albedo_red       <= x.alb[0];
        sample.albedo_green     <= x.alb[1];
        sample.albedo_blue      <= x.alb[2];
        sample.rough            <= x.rough;
        sample.cos_normal_view  <= x.cnv;
        sample.cos_normal_light <= x.cnl;
        sample.cos_light_view   <= x.clv;
        do
            @(posedge clk);
        while (!sample.ready);
    endtask

    function automatic shade_sample_t mk(int a0, int a1, int a2, int r, int v, int l, int lv);
        shade_sample_t x;
        x.alb[0] = ALBEDO_W'(a0);
        x.alb[1] = ALBEDO_W'(a1);
        x.alb[2] = ALBEDO_W'(a2);
        x.rough  = ALBEDO_W'(r);
        x.cnv    = COS_W'(v);
        x.cnl    = COS_W'(l);
        x.clv    = COS_W'(lv);
        return x;
    endfunction

    function automatic int rand_cos();
        if ($urandom_range(9) == 0)
            return $signed($urandom_range(262143) - 131072);
        return $signed($urandom_range(131072)) - 65536;
    endfunction

    function automatic shade_sample_t rand_sample();
        shade_sample_t x;
        for (int k = 0; k < 3; k++)
            x.alb[k] = ($urandom_range(9) == 0) ? ALBEDO_W'($urandom_range(131071))
                                                : ALBEDO_W'($urandom_range(65536));
        case ($urandom_range(9))
            0:       x.rough = '0;
            1:       x.rough = ALBEDO_W'($urandom_range(131071));
            2:       x.rough = ALBEDO_W'($urandom_range(3));
            default: x.rough = ALBEDO_W'($urandom_range(65536));
        endcase
        x.cnv = COS_W'(rand_cos());
        x.cnl = COS_W'(rand_cos());
        x.clv = COS_W'(rand_cos());
        return x;
    endfunction

    task automatic wait_drained();
        sample.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        shade_sample_t directed [$];
        repeat (5) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        directed.push_back(mk(0, 0, 0, 0, 65536, 65536, 65536));
        directed.push_back(mk(65536, 32768, 1, 0, 0, 0, 0));
        directed.push_back(mk(131071, 131071, 131071, 0, -131072, 131071, 0));
        directed.push_back(mk(65536, 65536, 65536, 65536, 65536, 65536, 65536));
        directed.push_back(mk(65536, 65536, 65536, 131071, 65536, 65536, -65536));
        directed.push_back(mk(131071, 131071, 131071, 65536, 1, 1, 131071));
        directed.push_back(mk(40000, 20000, 10000, 1, 30000, 50000, 20000));
        directed.push_back(mk(40000, 20000, 10000, 32768, -65536, -65536, -65536));
        directed.push_back(mk(40000, 20000, 10000, 32768, 0, 0, 65536));
        directed.push_back(mk(50000, 50000, 50000, 65536, 10000, 60000, 60000));
        directed.push_back(mk(50000, 50000, 50000, 65536, 60000, 10000, -60000));
        directed.push_back(mk(0, 65536, 131071, 100000, -131072, -131072, -131072));
        directed.push_back(mk(131071, 0, 65535, 65535, 131071, 131071, 131071));
        directed.push_back(mk(98304, 98304, 98304, 16384, 65536, 0, 0));
        foreach (directed[i])
            send_sample(directed[i]);

        // pause until every expected result is back
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            phase = n * 3 / N_RANDOM;
            if (n == N_RANDOM * 5 / 6)
                hold_req <= 1'b1;
            send_sample(rand_sample());
        end
        sample.valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
